// ===== rtl/salc_pkg.sv =====
// ============================================================================
// salc_pkg
// Shared types, codes and constants of the tag-only LRU cache model.
// ============================================================================
package salc_pkg;

    // Defaults of the geometry
    localparam int SETS_DEF = 256;
    localparam int WAYS_DEF = 8;

    // Line fields
    localparam int TAG_W = 30;
    localparam int AGE_W = 3;
    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    // Traffic constants
    localparam logic [2:0]  OFF_MIN       = 3'd2;
    localparam logic [18:0] WT_WORD_BYTES = 19'd4;
    localparam logic [18:0] WB_CAP        = 19'h7FFFF;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH = 2'd3;

    // Request opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef logic [3:0] way_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way_used;
        logic        dirty_evicted;
        logic [7:0]  read_bytes;
        logic [18:0] write_bytes;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } out_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } line_t;

    // Outcome of a scan over the ways of one set
    typedef struct packed {
        logic found;
        way_t hit_way;
        logic inv_found;
        way_t inv_way;
        way_t vic_way;
    } scan_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/set_assoc_lru_cache_model_top.sv =====
// ============================================================================
// set_assoc_lru_cache_model_top
// Tag-only set-associative cache with LRU replacement, write-back or
// write-through allocate, hit and miss totals.
// ============================================================================
// Usage:
//   Requests enter on in_valid/in_stall with in_data (opcode, address); one
//   result leaves per request on out_valid/out_stall with out_data. A
//   transaction completes at a clock edge with valid high and stall low.
//   Read/write: the set row is read from the row memory, the active ways
//   are scanned by one shared compare unit, one way per cycle, the row is
//   written back and the result is staged; one transaction at a time.
//   Drain: sweeps all SETS rows, one per cycle.
//   Unused opcode: returns a result that holds only the totals.
//   Reset and every configuration write start a clearing pass over all SETS
//   rows of the row memory; in_stall is high during it. Totals are zeroed.
//   A finished result waits in the output register while out_stall is high;
//   the next request is still taken and its result waits in a staging
//   register until the output register frees.
// ============================================================================
module set_assoc_lru_cache_model_top #(
    parameter int SETS = salc_pkg::SETS_DEF,
    parameter int WAYS = salc_pkg::WAYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  salc_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output salc_pkg::out_t                   out_data,
    input  logic                             cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [salc_pkg::CFG_W-1:0]       cfg_data
);
    import salc_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int PTR_W = $clog2(SETS + 1);
    localparam int SMAX  = $clog2(SETS + 1) - 1;
    localparam int CNT_W = $clog2(SETS * WAYS + 1);
    localparam int POP_W = $clog2(WAYS + 1);

    typedef line_t [WAYS-1:0] row_t;
    localparam int ROW_W = $bits(row_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_DRAIN,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [SET_W-1:0]  wptr_reg, wptr_next;
    logic [1:0]        op_reg, op_next;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [WAY_W-1:0]  wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        off_reg, off_next;
    logic [3:0]        sb_reg, sb_next;
    logic [1:0]        wl2_reg, wl2_next;
    logic              wt_reg, wt_next;
    logic [31:0]       hit_tot_reg, hit_tot_next;
    logic [31:0]       miss_tot_reg, miss_tot_next;
    out_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;

    // Memory and scanner hookup
    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr;
    row_t              mem_wdata;
    logic              mem_re;
    logic [SET_W-1:0]  mem_raddr;
    logic [ROW_W-1:0]  mem_rdata;
    row_t              rd_row;
    logic              scan_clear;
    logic              scan_en;
    scan_t             sr;

    // Derived configuration and address split
    logic [2:0]        off_eff;
    logic [3:0]        sb_eff;
    logic [31:0]       set_mask;
    logic [31:0]       in_set32;
    logic [31:0]       in_tag32;
    logic [7:0]        block;
    logic [4:0]        nw_pow;
    logic [WAY_W-1:0]  nm1;

    // Update of a row after a lookup
    logic              is_wr;
    way_t              used;
    logic              vic_dirty;
    logic              dirty_ev;
    row_t              upd_row;
    logic [31:0]       hit_upd;
    logic [31:0]       miss_upd;
    out_t              upd_res;

    // Drain row processing
    logic [POP_W-1:0]  row_pop;
    row_t              clr_row;
    logic [31:0]       cnt32;
    logic [31:0]       cap_sh;
    out_t              drain_res;
    out_t              none_res;
    logic              out_free;

    salc_mem #(
        .DEPTH (SETS),
        .WIDTH (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_row = mem_rdata;

    salc_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (scan_clear),
        .en    (scan_en),
        .way   (way_t'(wcnt_reg)),
        .line  (rd_row[wcnt_reg]),
        .tag   (tag_reg),
        .res   (sr)
    );

    // Clamp configuration and split the incoming address
    always_comb
    begin
        off_eff  = (off_reg < OFF_MIN) ? OFF_MIN : off_reg;
        sb_eff   = (sb_reg > 4'(SMAX)) ? 4'(SMAX) : sb_reg;
        set_mask = (32'd1 << sb_eff) - 32'd1;
        in_set32 = (in_data.address >> off_eff) & set_mask;
        in_tag32 = in_data.address >> (6'(off_eff) + 6'(sb_eff));
        block    = 8'd1 << off_eff;
        nw_pow   = 5'd1 << wl2_reg;
        if (nw_pow > 5'(WAYS))
        begin
            nm1 = WAY_W'(WAYS - 1);
        end
        else
        begin
            nm1 = WAY_W'(nw_pow - 5'd1);
        end
    end

    // Build the written-back row, traffic and totals of a lookup
    always_comb
    begin
        is_wr     = (op_reg == OP_WRITE);
        used      = sr.found ? sr.hit_way : (sr.inv_found ? sr.inv_way : sr.vic_way);
        vic_dirty = rd_row[sr.vic_way[WAY_W-1:0]].dirty;
        dirty_ev  = !sr.found && !sr.inv_found && !wt_reg && vic_dirty;
        upd_row   = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((WAY_W'(w) <= nm1) && (rd_row[w].age != AGE_MAX))
            begin
                upd_row[w].age = rd_row[w].age + 3'd1;
            end
        end
        upd_row[used[WAY_W-1:0]].age = '0;
        if (sr.found)
        begin
            if (is_wr && !wt_reg)
            begin
                upd_row[used[WAY_W-1:0]].dirty = 1'b1;
            end
        end
        else
        begin
            upd_row[used[WAY_W-1:0]].tag   = tag_reg;
            upd_row[used[WAY_W-1:0]].valid = 1'b1;
            upd_row[used[WAY_W-1:0]].dirty = is_wr && !wt_reg;
        end
        hit_upd  = sr.found ? sat_inc(hit_tot_reg) : hit_tot_reg;
        miss_upd = sr.found ? miss_tot_reg : sat_inc(miss_tot_reg);

        upd_res.hit           = sr.found;
        upd_res.way_used      = used[2:0];
        upd_res.dirty_evicted = dirty_ev;
        upd_res.read_bytes    = sr.found ? 8'd0 : block;
        if (is_wr && wt_reg)
        begin
            upd_res.write_bytes = WT_WORD_BYTES;
        end
        else if (dirty_ev)
        begin
            upd_res.write_bytes = 19'(block);
        end
        else
        begin
            upd_res.write_bytes = '0;
        end
        upd_res.hit_total  = hit_upd;
        upd_res.miss_total = miss_upd;
    end

    // Count and clear dirty lines of the row in flight during a drain
    always_comb
    begin
        row_pop = '0;
        clr_row = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            row_pop          = row_pop + POP_W'(rd_row[w].dirty);
            clr_row[w].dirty = 1'b0;
        end
        cnt32  = 32'(cnt_reg);
        cap_sh = 32'(WB_CAP) >> off_eff;

        drain_res            = '0;
        drain_res.write_bytes = (cnt32 > cap_sh) ? WB_CAP : 19'(cnt32 << off_eff);
        drain_res.hit_total  = hit_tot_reg;
        drain_res.miss_total = miss_tot_reg;

        none_res            = '0;
        none_res.hit_total  = hit_tot_reg;
        none_res.miss_total = miss_tot_reg;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || cfg_we;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        wptr_next      = wptr_reg;
        op_next        = op_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        wcnt_next      = wcnt_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        sb_next        = sb_reg;
        wl2_next       = wl2_reg;
        wt_next        = wt_reg;
        hit_tot_next   = hit_tot_reg;
        miss_tot_next  = miss_tot_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = wptr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = SET_W'(in_set32);
        scan_clear     = 1'b0;
        scan_en        = 1'b0;

        if (cfg_we)
        begin
            // Take the register, drop all lines and totals, restart clearing
            unique case (cfg_index)
                CFG_OFFSET_BITS:   off_next = cfg_data[2:0];
                CFG_SET_BITS:      sb_next  = cfg_data[3:0];
                CFG_WAYS_LOG2:     wl2_next = cfg_data[1:0];
                CFG_WRITE_THROUGH: wt_next  = cfg_data[0];
                default:           off_next = off_reg;
            endcase
            hit_tot_next  = '0;
            miss_tot_next = '0;
            ptr_next      = '0;
            pend_next     = 1'b0;
            state_next    = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[SET_W-1:0];
                    if (ptr_reg == PTR_W'(SETS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_next = in_data.opcode;
                        unique case (in_data.opcode) inside
                            OP_READ, OP_WRITE:
                            begin
                                set_next   = SET_W'(in_set32);
                                tag_next   = TAG_W'(in_tag32);
                                mem_re     = 1'b1;
                                scan_clear = 1'b1;
                                wcnt_next  = '0;
                                state_next = ST_SCAN;
                            end
                            OP_DRAIN:
                            begin
                                ptr_next   = '0;
                                pend_next  = 1'b0;
                                cnt_next   = '0;
                                state_next = ST_DRAIN;
                            end
                            default:
                            begin
                                res_next   = none_res;
                                state_next = ST_FIN;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    scan_en = 1'b1;
                    if (wcnt_reg == nm1)
                    begin
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg + WAY_W'(1);
                    end
                end
                ST_UPD:
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = set_reg;
                    mem_wdata     = upd_row;
                    hit_tot_next  = hit_upd;
                    miss_tot_next = miss_upd;
                    res_next      = upd_res;
                    state_next    = ST_FIN;
                end
                ST_DRAIN:
                begin
                    // Read the next row while the previous one is written back
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wptr_reg;
                        mem_wdata = clr_row;
                        cnt_next  = cnt_reg + CNT_W'(row_pop);
                    end
                    if (ptr_reg < PTR_W'(SETS))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg[SET_W-1:0];
                        ptr_next  = ptr_reg + PTR_W'(1);
                        wptr_next = ptr_reg[SET_W-1:0];
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            res_next   = drain_res;
                            state_next = ST_FIN;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_next       = res_reg;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            wptr_reg      <= '0;
            op_reg        <= OP_READ;
            set_reg       <= '0;
            tag_reg       <= '0;
            wcnt_reg      <= '0;
            cnt_reg       <= '0;
            off_reg       <= OFF_MIN;
            sb_reg        <= '0;
            wl2_reg       <= '0;
            wt_reg        <= 1'b0;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            wptr_reg      <= wptr_next;
            op_reg        <= op_next;
            set_reg       <= set_next;
            tag_reg       <= tag_next;
            wcnt_reg      <= wcnt_next;
            cnt_reg       <= cnt_next;
            off_reg       <= off_next;
            sb_reg        <= sb_next;
            wl2_reg       <= wl2_next;
            wt_reg        <= wt_next;
            hit_tot_reg   <= hit_tot_next;
            miss_tot_reg  <= miss_tot_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/salc_mem.sv =====
// ============================================================================
// salc_mem
// Row memory: one write port, one read port with registered read data.
// ============================================================================
module salc_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 280
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/salc_scan.sv =====
// ============================================================================
// salc_scan
// Shared way scanner: looks at one way per cycle while en is high and keeps
// the tag match, the first invalid way and the oldest way seen so far.
// ============================================================================
module salc_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         en,
    input  salc_pkg::way_t               way,
    input  salc_pkg::line_t              line,
    input  logic [salc_pkg::TAG_W-1:0]   tag,
    output salc_pkg::scan_t              res
);
    import salc_pkg::*;

    scan_t            res_reg;
    scan_t            res_next;
    logic [AGE_W-1:0] high_reg;
    logic [AGE_W-1:0] high_next;

    // Fold one way into the running result
    always_comb
    begin
        res_next  = res_reg;
        high_next = high_reg;
        if (clear)
        begin
            res_next  = '0;
            high_next = '0;
        end
        else if (en)
        begin
            if (!res_reg.found && line.valid && (line.tag == tag))
            begin
                res_next.found   = 1'b1;
                res_next.hit_way = way;
            end
            if (!res_reg.inv_found && !line.valid)
            begin
                res_next.inv_found = 1'b1;
                res_next.inv_way   = way;
            end
            if (line.age > high_reg)
            begin
                high_next        = line.age;
                res_next.vic_way = way;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            res_reg  <= res_next;
            high_reg <= high_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/salc_chk.sv =====
// ============================================================================
// salc_chk
// Port-level checks of the cache model, attached to the top level by bind.
// ============================================================================
module salc_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input salc_pkg::in_t                    in_data,
    input logic                             out_valid,
    input logic                             out_stall,
    input salc_pkg::out_t                   out_data,
    input logic                             cfg_we,
    input logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [salc_pkg::CFG_W-1:0]       cfg_data
);
    import salc_pkg::*;

    // One transaction at a time: the block stalls right after taking one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous one is in work");

    // A configuration write starts the clearing pass
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("no clearing pass after configuration write");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    // A hit fetches nothing from memory
    a_hit_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> (out_data.read_bytes == 8'd0))
        else $error("hit reports fetch traffic");

    // No result right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered out of reset");

endmodule

bind set_assoc_lru_cache_model_top salc_chk u_salc_chk (.*);
